[hw/rtl/rbst_pkg.sv]
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants for the ray and box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF = 8;
endpackage

[hw/rtl/rbst_recip.sv]
// ----------------------------------------------------------------------------
// rbst_recip
// Pipelined restoring divider that forms a saturated fixed-point reciprocal.
// ----------------------------------------------------------------------------
module rbst_recip import rbst_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned TAG_WIDTH = 1
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] dir,
  input  logic        [TAG_WIDTH-1:0]   tag_in,
  output logic signed [COORD_WIDTH-1:0] recip,
  output logic        [TAG_WIDTH-1:0]   tag_out
);
  // The quotient 2^(2F)/|d| has at most 2F+1 bits; one bit is found per stage.
  localparam int unsigned QW = 2 * FRAC_BITS + 1;
  localparam int unsigned MW = COORD_WIDTH;
  localparam logic [MW-1:0] FIX_MAX = {1'b0, {(MW-1){1'b1}}};
  localparam logic [MW-1:0] FIX_MIN = {1'b1, {(MW-1){1'b0}}};

  logic [MW-1:0]        mag [QW+1];
  logic [MW:0]          rem [QW+1];
  logic [QW-1:0]        quo [QW+1];
  logic                 neg [QW+1];
  logic                 zer [QW+1];
  logic [TAG_WIDTH-1:0] tag [QW+1];

  always_comb begin
    mag[0] = dir[MW-1] ? MW'(-dir) : dir;
    rem[0] = '0;
    quo[0] = '0;
    neg[0] = dir[MW-1];
    zer[0] = (dir == '0);
    tag[0] = tag_in;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [MW+1:0] shifted;
    logic [MW+1:0] trial;
    assign shifted = {rem[s], (s == 0) ? 1'b1 : 1'b0};
    assign trial = shifted - {2'b00, mag[s]};
    always_ff @(posedge clk) begin
      mag[s+1] <= mag[s];
      neg[s+1] <= neg[s];
      zer[s+1] <= zer[s];
      tag[s+1] <= tag[s];
      if (!trial[MW+1]) begin
        rem[s+1] <= trial[MW:0];
        quo[s+1] <= {quo[s][QW-2:0], 1'b1};
      end else begin
        rem[s+1] <= shifted[MW:0];
        quo[s+1] <= {quo[s][QW-2:0], 1'b0};
      end
    end
  end

  logic [QW:0] qx;
  logic [QW:0] qmax;
  assign qx = {1'b0, quo[QW]};
  assign qmax = (QW+1)'(FIX_MAX);

  always_ff @(posedge clk) begin
    tag_out <= tag[QW];
    if (zer[QW]) begin
      recip <= FIX_MAX;
    end else if (!neg[QW]) begin
      recip <= (qx > qmax) ? FIX_MAX : MW'(qx);
    end else begin
      recip <= (qx > qmax + 1'b1) ? FIX_MIN : MW'(-qx);
    end
  end
endmodule

[hw/rtl/ray_box_slab_test.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Tests whether a ray's line meets an axis-aligned box by the slab method.
// ----------------------------------------------------------------------------
// One item can be started in every cycle; busy is never raised. Its hit
// result appears with done for one cycle once it has passed the bit-per-stage
// reciprocal pipeline and the multiply, shift-and-select and compare stages
// that follow it. The receiver cannot stall.
module ray_box_slab_test import rbst_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] ray_origin_x,
  input  logic signed [COORD_WIDTH-1:0] ray_origin_y,
  input  logic signed [COORD_WIDTH-1:0] ray_origin_z,
  input  logic signed [COORD_WIDTH-1:0] ray_dir_x,
  input  logic signed [COORD_WIDTH-1:0] ray_dir_y,
  input  logic signed [COORD_WIDTH-1:0] ray_dir_z,
  input  logic signed [COORD_WIDTH-1:0] box_min_x,
  input  logic signed [COORD_WIDTH-1:0] box_min_y,
  input  logic signed [COORD_WIDTH-1:0] box_min_z,
  input  logic signed [COORD_WIDTH-1:0] box_max_x,
  input  logic signed [COORD_WIDTH-1:0] box_max_y,
  input  logic signed [COORD_WIDTH-1:0] box_max_z,
  output logic                          done,
  output logic                          hit
);
  localparam int unsigned W = COORD_WIDTH;
  localparam int unsigned DW = W + 1;
  localparam int unsigned PW = DW + W;
  localparam int unsigned QW = 2 * FRAC_BITS + 1;
  localparam int unsigned LAT = QW + 1;
  localparam logic signed [W-1:0] FIX_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] FIX_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [PW-1:0] PMAX = PW'(FIX_MAX);
  localparam logic signed [PW-1:0] PMIN = PW'(FIX_MIN);

  assign busy = 1'b0;

  logic signed [DW-1:0] dlo_in [3];
  logic signed [DW-1:0] dhi_in [3];
  logic signed [W-1:0]  dir_in [3];
  always_comb begin
    dlo_in[0] = DW'(box_min_x) - DW'(ray_origin_x);
    dhi_in[0] = DW'(box_max_x) - DW'(ray_origin_x);
    dlo_in[1] = DW'(box_min_y) - DW'(ray_origin_y);
    dhi_in[1] = DW'(box_max_y) - DW'(ray_origin_y);
    dlo_in[2] = DW'(box_min_z) - DW'(ray_origin_z);
    dhi_in[2] = DW'(box_max_z) - DW'(ray_origin_z);
    dir_in[0] = ray_dir_x;
    dir_in[1] = ray_dir_y;
    dir_in[2] = ray_dir_z;
  end

  // Differences and valid bits ride alongside the divider as a delay line.
  logic [2*DW-1:0] dly [3][LAT+1];
  logic [LAT:0]    vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-1:0], start};
    end
  end

  logic signed [W-1:0] rcp [3];
  logic signed [PW-1:0] plo [3];
  logic signed [PW-1:0] phi [3];
  logic                 rneg [3];
  logic signed [W-1:0]  tn [3];
  logic signed [W-1:0]  tf [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic unused_tag;
    rbst_recip #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .TAG_WIDTH(1)) u_recip (
      .clk(clk), .dir(dir_in[a]), .tag_in(1'b0), .recip(rcp[a]), .tag_out(unused_tag)
    );
    assign dly[a][0] = {dlo_in[a], dhi_in[a]};
    for (genvar s = 0; s < LAT; s++) begin : g_dly
      always_ff @(posedge clk) begin
        dly[a][s+1] <= dly[a][s];
      end
    end
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
    assign lo = dly[a][LAT][2*DW-1:DW];
    assign hi = dly[a][LAT][DW-1:0];
    always_ff @(posedge clk) begin
      plo[a] <= PW'(lo) * PW'(rcp[a]);
      phi[a] <= PW'(hi) * PW'(rcp[a]);
      rneg[a] <= rcp[a][W-1] & ~unused_tag;
    end
    logic signed [PW-1:0] slo;
    logic signed [PW-1:0] shi;
    logic signed [W-1:0]  dlo;
    logic signed [W-1:0]  dhi;
    always_comb begin
      slo = plo[a] >>> FRAC_BITS;
      shi = phi[a] >>> FRAC_BITS;
      dlo = (slo > PMAX) ? FIX_MAX : ((slo < PMIN) ? FIX_MIN : W'(slo));
      dhi = (shi > PMAX) ? FIX_MAX : ((shi < PMIN) ? FIX_MIN : W'(shi));
    end
    always_ff @(posedge clk) begin
      tn[a] <= rneg[a] ? dhi : dlo;
      tf[a] <= rneg[a] ? dlo : dhi;
    end
  end

  logic                ok_xy;
  logic signed [W-1:0] n_xy;
  logic signed [W-1:0] f_xy;
  logic signed [W-1:0] zn;
  logic signed [W-1:0] zf;
  always_ff @(posedge clk) begin
    ok_xy <= !(tn[0] > tf[1] || tn[1] > tf[0]);
    n_xy <= (tn[1] > tn[0]) ? tn[1] : tn[0];
    f_xy <= (tf[1] < tf[0]) ? tf[1] : tf[0];
    zn <= tn[2];
    zf <= tf[2];
  end

  logic [1:0] vtail;
  always_ff @(posedge clk) begin
    if (rst) begin
      vtail <= '0;
      done <= 1'b0;
    end else begin
      vtail <= {vtail[0], vld[LAT]};
      done <= vtail[1];
    end
    hit <= ok_xy && !(n_xy > zf || zn > f_xy);
  end
endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray and box slab test. Rays and boxes are sent
// through a start/busy handshake, a fixed-point slab predictor computes the
// expected hit flag, and a monitor compares each done-marked result with it.
// ----------------------------------------------------------------------------
module tb_top;
  import rbst_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint FIX_MAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint FIX_MIN = -FIX_MAX - 1;
  localparam int LATENCY = 2 * FB + 6;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    coord_t ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz;
  } ray_box_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, hit;
  ray_box_t cur = '0;

  ray_box_t pending_q[$];
  logic hit_q[$];
  int errors = 0;
  int idle_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ray_box_slab_test u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ray_origin_x(cur.ox), .ray_origin_y(cur.oy), .ray_origin_z(cur.oz),
    .ray_dir_x(cur.dx), .ray_dir_y(cur.dy), .ray_dir_z(cur.dz),
    .box_min_x(cur.lx), .box_min_y(cur.ly), .box_min_z(cur.lz),
    .box_max_x(cur.hx), .box_max_y(cur.hy), .box_max_z(cur.hz),
    .done(done), .hit(hit)
  );

  function automatic longint clamp(longint v);
    if (v > FIX_MAX) return FIX_MAX;
    if (v < FIX_MIN) return FIX_MIN;
    return v;
  endfunction

  function automatic void slab_range(longint o, longint d, longint lo, longint hi,
                                     output longint tn, output longint tf);
    longint r, a, b;
    r = (d == 0) ? FIX_MAX : clamp((64'sd1 <<< (2 * FB)) / d);
    a = clamp(((lo - o) * r) >>> FB);
    b = clamp(((hi - o) * r) >>> FB);
    if (r >= 0) begin
      tn = a; tf = b;
    end else begin
      tn = b; tf = a;
    end
  endfunction

  function automatic logic predict_hit(ray_box_t t);
    longint x0, x1, y0, y1, z0, z1;
    slab_range(t.ox, t.dx, t.lx, t.hx, x0, x1);
    slab_range(t.oy, t.dy, t.ly, t.hy, y0, y1);
    if (x0 > y1 || y0 > x1) return 1'b0;
    if (y0 > x0) x0 = y0;
    if (y1 < x1) x1 = y1;
    slab_range(t.oz, t.dz, t.lz, t.hz, z0, z1);
    return !(x0 > z1 || z0 > x1);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Presents a new item, or idles, at each falling edge after acceptance.
  always @(negedge clk) begin
    if (!rst && !(start && busy)) begin
      if (pending_q.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
        cur <= pending_q[0];
        hit_q.push_back(predict_hit(pending_q[0]));
        void'(pending_q.pop_front());
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (hit_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        if (hit !== hit_q[0]) begin
          report_mismatch($sformatf("hit %b, expected %b", hit, hit_q[0]));
        end
        void'(hit_q.pop_front());
      end
    end
  end

  function automatic coord_t pick_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(1024, 0) - 512);
      2: return coord_t'($urandom_range(16, 0) - 8);
      default: return $urandom_range(1, 0) ? coord_t'(FIX_MAX) : coord_t'(FIX_MIN);
    endcase
  endfunction

  function automatic ray_box_t random_item();
    ray_box_t t;
    int m;
    m = ($urandom_range(9, 0) < 7) ? 1 : 0;
    t.ox = pick_coord(m); t.oy = pick_coord(m); t.oz = pick_coord(m);
    t.dx = pick_coord($urandom_range(3, 0)); t.dy = pick_coord($urandom_range(3, 0));
    t.dz = pick_coord($urandom_range(3, 0));
    if ($urandom_range(9, 0) == 0) t.dx = '0;
    if ($urandom_range(9, 0) == 0) t.dy = '0;
    if ($urandom_range(9, 0) == 0) t.dz = '0;
    t.lx = pick_coord(m); t.ly = pick_coord(m); t.lz = pick_coord(m);
    t.hx = pick_coord(m); t.hy = pick_coord(m); t.hz = pick_coord(m);
    // Mostly well-ordered boxes; the rest keep their random order.
    if ($urandom_range(9, 0) < 8) begin
      if (t.lx > t.hx) {t.lx, t.hx} = {t.hx, t.lx};
      if (t.ly > t.hy) {t.ly, t.hy} = {t.hy, t.ly};
      if (t.lz > t.hz) {t.lz, t.hz} = {t.hz, t.lz};
    end
    return t;
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_q.size() > 0 || hit_q.size() > 0) && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    ray_box_t t;
    coord_t ext[4];
    ext = '{coord_t'(FIX_MAX), coord_t'(FIX_MIN), coord_t'(0), coord_t'(-1)};
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: plain hit and miss, zero directions, ties, inverted box, extremes.
    t = '{ox: 0, oy: 0, oz: 0, dx: 256, dy: 256, dz: 256,
          lx: 256, ly: 256, lz: 256, hx: 512, hy: 512, hz: 512};
    pending_q.push_back(t);
    t.ly = 1024; t.hy = 1280; pending_q.push_back(t);
    t = '{ox: 0, oy: 0, oz: 0, dx: 0, dy: 0, dz: 0,
          lx: -1, ly: -1, lz: -1, hx: 1, hy: 1, hz: 1};
    pending_q.push_back(t);
    t.lx = 1; pending_q.push_back(t);
    t = '{ox: 0, oy: 0, oz: 0, dx: 256, dy: -256, dz: 1,
          lx: 256, ly: 256, lz: 256, hx: 256, hy: 256, hz: 256};
    pending_q.push_back(t);
    t.lx = 512; t.hx = 0; pending_q.push_back(t);
    t.dx = -1; t.dy = 32767; t.dz = -32768; pending_q.push_back(t);
    for (int i = 0; i < 16; i++) begin
      t.ox = ext[i % 4]; t.oy = ext[(i + 1) % 4]; t.oz = ext[(i + 2) % 4];
      t.dx = ext[i / 4]; t.dy = ext[(i + 3) % 4]; t.dz = ext[(i / 4 + 1) % 4];
      t.lx = ext[(i + 1) % 4]; t.ly = ext[i % 4]; t.lz = ext[(i + 3) % 4];
      t.hx = ext[(i + 2) % 4]; t.hy = ext[i / 4]; t.hz = ext[i % 4];
      pending_q.push_back(t);
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 57 : (ph == 2) ? 12 : 0;
      for (int i = 0; i < 330; i++) pending_q.push_back(random_item());
      drain();
    end

    if (pending_q.size() != 0 || hit_q.size() != 0) begin
      report_mismatch("items still outstanding at the end of the run");
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

[ray_box_slab_test.f]
hw/rtl/rbst_pkg.sv
hw/rtl/rbst_recip.sv
hw/rtl/ray_box_slab_test.sv
bench/tb_top.sv
